@@ hw/rtl/flbh_pkg.sv @@
// four-lane byte hash: shared types, constants and helper functions
// no dependencies; used by the interfaces, controller, datapath and top level
package flbh_pkg;

    localparam int NUM_LANES  = 4;
    localparam int WORD_W     = 64;
    localparam int CMD_W      = 2;
    localparam int LANE_W     = 2;
    localparam int BYTE_SEL_W = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [WORD_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX1   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX2   = 64'h94d049bb133111eb;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE3 = 3'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE   = 2'd0,
        CMD_WORD   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MLL,
        ST_MLH,
        ST_MHL,
        ST_WRITE,
        ST_FLOAD,
        ST_FMID,
        ST_FOUT,
        ST_CLEAR
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ABS_LOAD,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_ABS_WRITE,
        OP_FIN_LOAD,
        OP_FIN_MID,
        OP_FIN_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        K_SALT,
        K_MIX1,
        K_MIX2
    } k_sel_t;

    // controller to datapath
    typedef struct packed {
        logic                  capture;
        dp_op_t                op;
        k_sel_t                k_sel;
        logic [LANE_W-1:0]     lane;
        logic [BYTE_SEL_W-1:0] byte_sel;
        logic                  last_lane;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] salt_of(input logic [LANE_W-1:0] lane);
        logic [WORD_W-1:0] s;
        unique case (lane)
            2'd0: s = 64'h9e3779b97f4a7c15;
            2'd1: s = 64'hd1b54a32d192ed03;
            2'd2: s = 64'h94d049bb133111eb;
            2'd3: s = 64'hbf58476d1ce4e5b9;
            default: s = '0;
        endcase
        return s;
    endfunction

    // golden constant times (lane + 1), folded at elaboration
    function automatic logic [WORD_W-1:0] golden_of(input logic [LANE_W-1:0] lane);
        logic [WORD_W-1:0] g;
        unique case (lane)
            2'd0: g = WORD_W'(GOLDEN * 64'd1);
            2'd1: g = WORD_W'(GOLDEN * 64'd2);
            2'd2: g = WORD_W'(GOLDEN * 64'd3);
            2'd3: g = WORD_W'(GOLDEN * 64'd4);
            default: g = '0;
        endcase
        return g;
    endfunction

    // rotate left by 11 + 8 * lane
    function automatic logic [WORD_W-1:0] rotl_lane(input logic [WORD_W-1:0] x,
                                                    input logic [LANE_W-1:0] lane);
        logic [WORD_W-1:0] r;
        unique case (lane)
            2'd0: r = {x[52:0], x[63:53]};
            2'd1: r = {x[44:0], x[63:45]};
            2'd2: r = {x[36:0], x[63:37]};
            2'd3: r = {x[28:0], x[63:29]};
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/flbh_if.sv @@
// four-lane byte hash: valid/ready channel interfaces (input, result, config)
// depends on flbh_pkg for field widths
interface flbh_in_if;
    logic                         valid;
    logic                         ready;
    logic [flbh_pkg::CMD_W-1:0]   command;
    logic [flbh_pkg::WORD_W-1:0]  data;

    modport source (output valid, output command, output data, input ready);
    modport sink   (input valid, input command, input data, output ready);
endinterface

interface flbh_out_if;
    logic                         valid;
    logic                         ready;
    logic [flbh_pkg::LANE_W-1:0]  lane_index;
    logic [flbh_pkg::WORD_W-1:0]  digest_word;
    logic                         last;

    modport source (output valid, output lane_index, output digest_word, output last,
                    input ready);
    modport sink   (input valid, input lane_index, input digest_word, input last,
                    output ready);
endinterface

interface flbh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [flbh_pkg::CFG_IDX_W-1:0] index;
    logic [flbh_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/four_lane_byte_hash.sv @@
// four-lane byte hash top level: controller plus datapath behind valid/ready channels
// depends on flbh_pkg, flbh_if, flbh_ctrl and flbh_datapath
//
//   channel   dir  payload                               transfer when
//   in_ch     in   command[1:0], data[63:0]              valid && ready
//   out_ch    out  lane_index[1:0], digest_word[63:0],   valid && ready
//                  last
//   cfg       in   index[2:0], data[63:0]                valid && ready (ready tied high)
//
// steps after the accept: byte absorb is LOAD, MLL, MLH, MHL, WRITE per lane; word absorb
//   repeats that per byte; finish is FLOAD, mul, FMID, mul, FOUT per lane plus any output
//   stall; clear is CLEAR; mul is MLL, MLH, MHL on the shared 32x32 multiplier (64-bit low product)
// reset: rst_n clears lanes, byte count, seeds and the output valid flag at once
// stalls: the result register holds while out_ch.ready is low; a finish waits per
//   digest word for that register to free, and in_ch is taken only between items
// seed writes are registered and affect the lanes only at the next clear
module four_lane_byte_hash (
    input  logic             clk,
    input  logic             rst_n,
    flbh_in_if.sink          in_ch,
    flbh_out_if.source       out_ch,
    flbh_cfg_if.sink         cfg
);

    flbh_pkg::dp_cmd_t    cmd;
    flbh_pkg::dp_status_t status;

    // config is accepted in any cycle
    assign cfg.ready = 1'b1;

    flbh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    flbh_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_data         (in_ch.data),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_lane_index  (out_ch.lane_index),
        .out_digest_word (out_ch.digest_word),
        .out_last        (out_ch.last)
    );

    // last marks exactly the final lane of a digest
    a_last_lane: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.last == (out_ch.lane_index ==
                          flbh_pkg::LANE_W'(flbh_pkg::NUM_LANES - 1))))
        else $error("last flag does not match lane index");

    // a digest word is only loaded when the result register can take it
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == flbh_pkg::OP_FIN_OUT) |-> status.out_free)
        else $error("digest overwrote a pending result");

    // the datapath is quiet while a new item can be taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (cmd.op == flbh_pkg::OP_NONE))
        else $error("datapath busy while accepting input");

    // after a loaded digest word the output is valid with that lane
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == flbh_pkg::OP_FIN_OUT) |=>
            (out_ch.valid && (out_ch.lane_index == $past(cmd.lane))))
        else $error("digest word not presented after load");

endmodule

@@ hw/rtl/flbh_ctrl.sv @@
// four-lane byte hash: sequencing state machine
// depends on flbh_pkg; drives the datapath through dp_cmd_t
module flbh_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [flbh_pkg::CMD_W-1:0]   in_command,
    output logic                         in_ready,
    input  flbh_pkg::dp_status_t         status,
    output flbh_pkg::dp_cmd_t            cmd
);

    flbh_pkg::state_t                    state_reg, state_next;
    logic [flbh_pkg::LANE_W-1:0]         lane_reg, lane_next;
    logic [flbh_pkg::BYTE_SEL_W-1:0]     byte_reg, byte_next;
    logic                                word_reg, word_next;
    logic                                fin_reg, fin_next;
    logic                                phase_reg, phase_next;
    logic                                last_lane;
    logic                                fire;

    assign last_lane = (lane_reg == flbh_pkg::LANE_W'(flbh_pkg::NUM_LANES - 1));
    assign in_ready  = (state_reg == flbh_pkg::ST_IDLE);
    assign fire      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= flbh_pkg::ST_IDLE;
            lane_reg  <= '0;
            byte_reg  <= '0;
            word_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            byte_reg  <= byte_next;
            word_reg  <= word_next;
            fin_reg   <= fin_next;
            phase_reg <= phase_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        byte_next  = byte_reg;
        word_next  = word_reg;
        fin_next   = fin_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            flbh_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    lane_next  = '0;
                    byte_next  = '0;
                    phase_next = 1'b0;
                    word_next  = (flbh_pkg::cmd_t'(in_command) == flbh_pkg::CMD_WORD);
                    fin_next   = (flbh_pkg::cmd_t'(in_command) == flbh_pkg::CMD_FINISH);
                    unique case (flbh_pkg::cmd_t'(in_command))
                        flbh_pkg::CMD_BYTE:   state_next = flbh_pkg::ST_LOAD;
                        flbh_pkg::CMD_WORD:   state_next = flbh_pkg::ST_LOAD;
                        flbh_pkg::CMD_FINISH: state_next = flbh_pkg::ST_FLOAD;
                        flbh_pkg::CMD_CLEAR:  state_next = flbh_pkg::ST_CLEAR;
                        default:              state_next = flbh_pkg::ST_IDLE;
                    endcase
                end
            end
            flbh_pkg::ST_LOAD:  state_next = flbh_pkg::ST_MLL;
            flbh_pkg::ST_MLL:   state_next = flbh_pkg::ST_MLH;
            flbh_pkg::ST_MLH:   state_next = flbh_pkg::ST_MHL;
            flbh_pkg::ST_MHL:
            begin
                priority if (!fin_reg)
                    state_next = flbh_pkg::ST_WRITE;
                else if (!phase_reg)
                    state_next = flbh_pkg::ST_FMID;
                else
                    state_next = flbh_pkg::ST_FOUT;
            end
            flbh_pkg::ST_WRITE:
            begin
                priority if (!last_lane)
                begin
                    lane_next  = lane_reg + 1'b1;
                    state_next = flbh_pkg::ST_LOAD;
                end
                else if (word_reg && (byte_reg != '1))
                begin
                    lane_next  = '0;
                    byte_next  = byte_reg + 1'b1;
                    state_next = flbh_pkg::ST_LOAD;
                end
                else
                    state_next = flbh_pkg::ST_IDLE;
            end
            flbh_pkg::ST_FLOAD: state_next = flbh_pkg::ST_MLL;
            flbh_pkg::ST_FMID:
            begin
                phase_next = 1'b1;
                state_next = flbh_pkg::ST_MLL;
            end
            flbh_pkg::ST_FOUT:
            begin
                if (status.out_free)
                begin
                    phase_next = 1'b0;
                    if (last_lane)
                        state_next = flbh_pkg::ST_IDLE;
                    else
                    begin
                        lane_next  = lane_reg + 1'b1;
                        state_next = flbh_pkg::ST_FLOAD;
                    end
                end
            end
            flbh_pkg::ST_CLEAR: state_next = flbh_pkg::ST_IDLE;
            default:            state_next = flbh_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.capture   = fire;
        cmd.lane      = lane_reg;
        cmd.byte_sel  = byte_reg;
        cmd.last_lane = last_lane;
        priority if (!fin_reg)
            cmd.k_sel = flbh_pkg::K_SALT;
        else if (!phase_reg)
            cmd.k_sel = flbh_pkg::K_MIX1;
        else
            cmd.k_sel = flbh_pkg::K_MIX2;
        unique case (state_reg)
            flbh_pkg::ST_IDLE:  cmd.op = flbh_pkg::OP_NONE;
            flbh_pkg::ST_LOAD:  cmd.op = flbh_pkg::OP_ABS_LOAD;
            flbh_pkg::ST_MLL:   cmd.op = flbh_pkg::OP_MUL_LL;
            flbh_pkg::ST_MLH:   cmd.op = flbh_pkg::OP_MUL_LH;
            flbh_pkg::ST_MHL:   cmd.op = flbh_pkg::OP_MUL_HL;
            flbh_pkg::ST_WRITE: cmd.op = flbh_pkg::OP_ABS_WRITE;
            flbh_pkg::ST_FLOAD: cmd.op = flbh_pkg::OP_FIN_LOAD;
            flbh_pkg::ST_FMID:  cmd.op = flbh_pkg::OP_FIN_MID;
            flbh_pkg::ST_FOUT:  cmd.op = status.out_free ? flbh_pkg::OP_FIN_OUT
                                                         : flbh_pkg::OP_NONE;
            flbh_pkg::ST_CLEAR: cmd.op = flbh_pkg::OP_CLEAR;
            default:            cmd.op = flbh_pkg::OP_NONE;
        endcase
    end

endmodule

@@ hw/rtl/flbh_datapath.sv @@
// four-lane byte hash: lane state, seeds, shared 32x32 multiplier, output register
// depends on flbh_pkg; commanded by flbh_ctrl
module flbh_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  flbh_pkg::dp_cmd_t              cmd,
    output flbh_pkg::dp_status_t           status,
    input  logic [flbh_pkg::WORD_W-1:0]    in_data,
    input  logic                           cfg_valid,
    input  logic [flbh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [flbh_pkg::WORD_W-1:0]    cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [flbh_pkg::LANE_W-1:0]    out_lane_index,
    output logic [flbh_pkg::WORD_W-1:0]    out_digest_word,
    output logic                           out_last
);

    localparam int W = flbh_pkg::WORD_W;
    localparam int H = W / 2;

    logic [W-1:0] seed_reg  [flbh_pkg::NUM_LANES];
    logic [W-1:0] seed_next [flbh_pkg::NUM_LANES];
    logic [W-1:0] lane_reg  [flbh_pkg::NUM_LANES];
    logic [W-1:0] lane_next [flbh_pkg::NUM_LANES];
    logic [W-1:0] count_reg, count_next;
    logic [W-1:0] data_reg, data_next;
    logic [W-1:0] v_reg, v_next;
    logic [W-1:0] acc_reg, acc_next;
    logic         out_valid_reg, out_valid_next;
    logic [flbh_pkg::LANE_W-1:0] out_lane_reg, out_lane_next;
    logic [W-1:0] out_digest_reg, out_digest_next;
    logic         out_last_reg, out_last_next;

    logic [W-1:0] k_word;
    logic [H-1:0] mul_a, mul_b;
    logic [W-1:0] product;
    logic [W-1:0] cur_lane;
    logic [7:0]   cur_byte;
    logic [W-1:0] fin_x;

    assign cur_lane = lane_reg[cmd.lane];
    assign cur_byte = data_reg[8*cmd.byte_sel +: 8];
    assign fin_x    = cur_lane ^ (count_reg + flbh_pkg::golden_of(cmd.lane));

    always_comb
    begin
        unique case (cmd.k_sel)
            flbh_pkg::K_SALT: k_word = flbh_pkg::salt_of(cmd.lane + 1'b1) | W'(1);
            flbh_pkg::K_MIX1: k_word = flbh_pkg::MIX1;
            flbh_pkg::K_MIX2: k_word = flbh_pkg::MIX2;
            default:          k_word = flbh_pkg::MIX1;
        endcase
    end

    // one partial product per cycle; only the low 64 bits of the full product are kept
    assign mul_a   = (cmd.op == flbh_pkg::OP_MUL_HL) ? v_reg[W-1:H] : v_reg[H-1:0];
    assign mul_b   = (cmd.op == flbh_pkg::OP_MUL_LH) ? k_word[W-1:H] : k_word[H-1:0];
    assign product = W'(mul_a) * W'(mul_b);

    always_comb
    begin
        seed_next       = seed_reg;
        lane_next       = lane_reg;
        count_next      = count_reg;
        data_next       = data_reg;
        v_next          = v_reg;
        acc_next        = acc_reg;
        out_lane_next   = out_lane_reg;
        out_digest_next = out_digest_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cfg_valid && (cfg_index < flbh_pkg::CFG_IDX_W'(flbh_pkg::NUM_LANES)))
            seed_next[cfg_index[flbh_pkg::LANE_W-1:0]] = cfg_data;

        if (cmd.capture)
            data_next = in_data;

        unique case (cmd.op)
            flbh_pkg::OP_NONE: ;
            flbh_pkg::OP_CLEAR:
            begin
                lane_next  = seed_reg;
                count_next = '0;
            end
            flbh_pkg::OP_ABS_LOAD:
                v_next = flbh_pkg::rotl_lane(
                    cur_lane ^ (W'(cur_byte) + flbh_pkg::salt_of(cmd.lane)), cmd.lane);
            flbh_pkg::OP_MUL_LL:
                acc_next = product;
            flbh_pkg::OP_MUL_LH, flbh_pkg::OP_MUL_HL:
                acc_next = acc_reg + {product[H-1:0], {H{1'b0}}};
            flbh_pkg::OP_ABS_WRITE:
            begin
                lane_next[cmd.lane] = acc_reg + count_reg;
                if (cmd.last_lane)
                    count_next = count_reg + W'(1);
            end
            flbh_pkg::OP_FIN_LOAD:
                v_next = fin_x ^ (fin_x >> 30);
            flbh_pkg::OP_FIN_MID:
                v_next = acc_reg ^ (acc_reg >> 27);
            flbh_pkg::OP_FIN_OUT:
            begin
                out_valid_next  = 1'b1;
                out_lane_next   = cmd.lane;
                out_digest_next = acc_reg ^ (acc_reg >> 31);
                out_last_next   = cmd.last_lane;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < flbh_pkg::NUM_LANES; i++)
            begin
                seed_reg[i] <= '0;
                lane_reg[i] <= '0;
            end
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            lane_reg      <= lane_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg       <= data_next;
        v_reg          <= v_next;
        acc_reg        <= acc_next;
        out_lane_reg   <= out_lane_next;
        out_digest_reg <= out_digest_next;
        out_last_reg   <= out_last_next;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_lane_index  = out_lane_reg;
    assign out_digest_word = out_digest_reg;
    assign out_last        = out_last_reg;

endmodule
